FILE: rtl/cps_pkg.sv
// ----------------------------------------------------------------------------
// cps_pkg
// Shared types and constants for the closest point on segment block.
// ----------------------------------------------------------------------------
package cps_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int CFG_INDEX_WIDTH = 2;

  typedef enum logic [1:0] {
    WF_INTERIOR = 2'd0,
    WF_START    = 2'd1,
    WF_END      = 2'd2,
    WF_DEGEN    = 2'd3
  } where_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_START_X = 2'd0,
    REG_START_Y = 2'd1,
    REG_END_X   = 2'd2,
    REG_END_Y   = 2'd3
  } cfg_reg_t;

endpackage

FILE: rtl/cps_lane.sv
// ----------------------------------------------------------------------------
// cps_lane
// One axis: start + trunc(num * d / len2), with a multiply stage, one
// restoring divider stage per quotient bit and a final add stage.
// ----------------------------------------------------------------------------
module cps_lane #(
  parameter int W = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [2*W+1:0]       num,
  input  logic [2*W+1:0]       len2,
  input  logic signed [W:0]    d,
  input  logic signed [W-1:0]  s,
  output logic [W-1:0]         near
);

  localparam int NW = 2*W + 2;
  localparam int PW = NW + W + 1;

  logic [W:0]    mag;
  logic [PW-1:0] rem [W+2];
  logic [NW-1:0] len [W+2];
  logic [W-1:0]  st  [W+2];
  logic          ng  [W+2];
  logic [W:0]    qv  [W+2];
  logic [W:0]    sum;

  assign mag = d[W] ? (~d + 1'b1) : d;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num * mag;
      len[0] <= len2;
      st[0]  <= s;
      ng[0]  <= d[W];
      qv[0]  <= '0;
    end
  end

  // Quotient is at most |d|, so W+1 bits are enough; the top bit comes first.
  for (genvar k = 0; k <= W; k++) begin : g_div
    localparam int SH = W - k;
    logic [PW-1:0] dv;
    logic          ge;
    assign dv = {{(PW-NW){1'b0}}, len[k]} << SH;
    assign ge = rem[k] >= dv;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? rem[k] - dv : rem[k];
        len[k+1] <= len[k];
        st[k+1]  <= st[k];
        ng[k+1]  <= ng[k];
        qv[k+1]  <= qv[k] | ({{W{1'b0}}, ge} << SH);
      end
    end
  end

  assign sum = ng[W+1] ? {st[W+1][W-1], st[W+1]} - qv[W+1]
                       : {st[W+1][W-1], st[W+1]} + qv[W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      near <= sum[W-1:0];
    end
  end

endmodule

FILE: rtl/closest_point_on_segment_2d_top.sv
// Throughput: one word per cycle; the whole pipeline advances together and
// holds when the output word is not taken. Most of the depth is in the divider,
// one stage per quotient bit in each axis lane.
// Reset clears the valid bits and the segment registers to zero.
// ----------------------------------------------------------------------------
// closest_point_on_segment_2d_top
// Nearest point on a configured segment to a stream of query points.
// ----------------------------------------------------------------------------
module closest_point_on_segment_2d_top #(
  parameter int COORD_WIDTH = cps_pkg::COORD_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr,
  input  logic [cps_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]             cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [COORD_WIDTH-1:0]             query_x,
  input  logic [COORD_WIDTH-1:0]             query_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [COORD_WIDTH-1:0]             near_x,
  output logic [COORD_WIDTH-1:0]             near_y,
  output logic [1:0]                         where_found
);

  import cps_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int L  = W + 3;
  localparam int N  = 4 + L;

  logic signed [W-1:0] start_x, start_y, end_x, end_y;
  logic [N-1:0]        vld;
  logic                en;

  logic signed [W:0]     dpx1, dpy1, dx1, dy1;
  logic signed [2*W+1:0] pxx2, pyy2, dxx2, dyy2;
  logic signed [2*W+2:0] num3;
  logic [2*W+1:0]        len3;
  logic [2*W+1:0]        num4, len4;
  where_t                w4;
  where_t                wp [L];

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= '0;
      start_y <= '0;
      end_x   <= '0;
      end_y   <= '0;
    end else if (cfg_wr) begin
      case (cfg_reg_t'(cfg_index))
        REG_START_X: start_x <= cfg_data;
        REG_START_Y: start_y <= cfg_data;
        REG_END_X:   end_x   <= cfg_data;
        REG_END_Y:   end_y   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en        = !vld[N-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dpx1 <= $signed({query_x[W-1], query_x}) - $signed({start_x[W-1], start_x});
      dpy1 <= $signed({query_y[W-1], query_y}) - $signed({start_y[W-1], start_y});
      dx1  <= $signed({end_x[W-1], end_x}) - $signed({start_x[W-1], start_x});
      dy1  <= $signed({end_y[W-1], end_y}) - $signed({start_y[W-1], start_y});
      pxx2 <= dpx1 * dx1;
      pyy2 <= dpy1 * dy1;
      dxx2 <= dx1 * dx1;
      dyy2 <= dy1 * dy1;
      num3 <= pxx2 + pyy2;
      len3 <= {1'b0, dxx2[2*W:0]} + {1'b0, dyy2[2*W:0]};
      // Clamped cases reuse the lane: num = 0 gives start, num = len2 gives end.
      // A degenerate segment divides zero by one so the lane returns start.
      if (len3 == '0) begin
        w4   <= WF_DEGEN;
        num4 <= '0;
        len4 <= {{(2*W+1){1'b0}}, 1'b1};
      end else if (num3[2*W+2]) begin
        w4   <= WF_START;
        num4 <= '0;
        len4 <= len3;
      end else if (num3 > $signed({1'b0, len3})) begin
        w4   <= WF_END;
        num4 <= len3;
        len4 <= len3;
      end else begin
        w4   <= WF_INTERIOR;
        num4 <= num3[2*W+1:0];
        len4 <= len3;
      end
      wp[0] <= w4;
      for (int i = 1; i < L; i++) begin
        wp[i] <= wp[i-1];
      end
    end
  end

  cps_lane #(.W(W)) u_lane_x (
    .clk  (clk),
    .en   (en),
    .num  (num4),
    .len2 (len4),
    .d    ($signed({end_x[W-1], end_x}) - $signed({start_x[W-1], start_x})),
    .s    (start_x),
    .near (near_x)
  );

  cps_lane #(.W(W)) u_lane_y (
    .clk  (clk),
    .en   (en),
    .num  (num4),
    .len2 (len4),
    .d    ($signed({end_y[W-1], end_y}) - $signed({start_y[W-1], start_y})),
    .s    (start_y),
    .near (near_y)
  );

  assign where_found = wp[L-1];

  a_start_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid && (where_found == WF_START || where_found == WF_DEGEN)
      |-> near_x == start_x && near_y == start_y)
    else $error("clamped result is not the start point");

  a_end_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid && where_found == WF_END |-> near_x == end_x && near_y == end_y)
    else $error("clamped result is not the end point");

  a_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted word did not enter the pipeline");

endmodule
